[hdl/eg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// eg_pkg
// Shared constants and types for the euclidean gcd core.
// ----------------------------------------------------------------------------
package eg_pkg;

  // default operand width
  localparam int unsigned DEF_WIDTH = 32;

  // status of the shared remainder unit as seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } rem_sts_t;

endpackage
`default_nettype wire

[hdl/eg_intf.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// eg_intf
// Valid/ready channels for operand pairs and gcd results.
// ----------------------------------------------------------------------------
interface eg_in_if #(
  parameter int unsigned WIDTH = eg_pkg::DEF_WIDTH
) ();
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] operand_a;
  logic [WIDTH-1:0] operand_b;

  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface eg_out_if #(
  parameter int unsigned WIDTH = eg_pkg::DEF_WIDTH
) ();
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] divisor;
  logic             both_zero;

  modport source (output valid, output divisor, output both_zero, input ready);
  modport sink   (input valid, input divisor, input both_zero, output ready);
endinterface
`default_nettype wire

[hdl/eg_rem_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// eg_rem_unit
// Restoring remainder unit: one quotient bit per cycle, one step per dividend
// bit; done pulses in the cycle after the last step.
// ----------------------------------------------------------------------------
module eg_rem_unit #(
  parameter int unsigned WIDTH = eg_pkg::DEF_WIDTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [WIDTH-1:0] dividend_i,
  input  wire logic [WIDTH-1:0] divisor_i,
  output eg_pkg::rem_sts_t      sts_o,
  output logic      [WIDTH-1:0] remainder_o
);

  localparam int unsigned CntW = $clog2(WIDTH);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [WIDTH-1:0] dvd_q, dvd_d;
  logic [WIDTH-1:0] dvs_q, dvs_d;
  logic [WIDTH-1:0] rem_q, rem_d;

  logic [WIDTH:0] trial;
  logic [WIDTH:0] diff;

  assign trial = {rem_q, dvd_q[WIDTH-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(WIDTH - 1);
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // keep the difference unless the subtract borrowed
      rem_d = diff[WIDTH] ? trial[WIDTH-1:0] : diff[WIDTH-1:0];
      dvd_d = {dvd_q[WIDTH-2:0], 1'b0};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign sts_o.busy  = busy_q;
  assign sts_o.done  = done_q;
  assign remainder_o = rem_q;

endmodule
`default_nettype wire

[hdl/euclid_gcd_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// euclid_gcd_core
// Greatest common divisor of two unsigned operands by repeated remainders.
// ----------------------------------------------------------------------------
// One operand pair at a time. After a transfer the core repeats
// (x, y) <= (y, x mod y) until y is zero and then presents x as the divisor.
// Each remainder step runs on a single shared restoring remainder unit; for
// 32-bit operands a pair needs at most 46 steps (consecutive Fibonacci
// numbers with the smaller one first). A zero second operand needs no
// remainder step. Both operands zero gives divisor 0 with both_zero set.
// The input is not ready while a pair is in progress; the result sits in an
// output register, so a finished result may wait while the next pair is
// taken in.
module euclid_gcd_core #(
  parameter int unsigned WIDTH = eg_pkg::DEF_WIDTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  eg_in_if.sink     in_i,
  eg_out_if.source  out_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOP   = 2'd1;
  localparam logic [1:0] ST_WAIT   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [WIDTH-1:0] x_q, x_d;
  logic [WIDTH-1:0] y_q, y_d;
  logic             zero_q, zero_d;
  logic             ovalid_q, ovalid_d;
  logic [WIDTH-1:0] odiv_q, odiv_d;
  logic             ozero_q, ozero_d;

  logic             rem_start;
  eg_pkg::rem_sts_t rem_sts;
  logic [WIDTH-1:0] rem;

  eg_rem_unit #(
    .WIDTH (WIDTH)
  ) u_rem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (rem_start),
    .dividend_i  (x_q),
    .divisor_i   (y_q),
    .sts_o       (rem_sts),
    .remainder_o (rem)
  );

  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    x_d       = x_q;
    y_d       = y_q;
    zero_d    = zero_q;
    ovalid_d  = ovalid_q;
    odiv_d    = odiv_q;
    ozero_d   = ozero_q;
    rem_start = 1'b0;

    if (out_o.valid && out_o.ready) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          x_d     = in_i.operand_a;
          y_d     = in_i.operand_b;
          zero_d  = (in_i.operand_a == '0) && (in_i.operand_b == '0);
          state_d = ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (y_q == '0) begin
          state_d = ST_FINISH;
        end else begin
          rem_start = 1'b1;
          state_d   = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (rem_sts.done) begin
          x_d     = y_q;
          y_d     = rem;
          state_d = ST_LOOP;
        end
      end
      ST_FINISH: begin
        // hand over once the output register is free
        if (!ovalid_d) begin
          ovalid_d = 1'b1;
          odiv_d   = x_q;
          ozero_d  = zero_q;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    zero_q  <= zero_d;
    odiv_q  <= odiv_d;
    ozero_q <= ozero_d;
  end

  assign out_o.valid     = ovalid_q;
  assign out_o.divisor   = odiv_q;
  assign out_o.both_zero = ozero_q;

`ifndef SYNTHESIS
  a_idle_unit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !rem_sts.busy)
    else $error("remainder unit busy while core accepts operands");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_sts.done |-> (state_q == ST_WAIT))
    else $error("remainder done outside of wait state");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_sts.done |-> (rem < y_q))
    else $error("remainder not below divisor");

  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.both_zero) |-> (out_o.divisor == '0))
    else $error("both_zero result with nonzero divisor");
`endif

endmodule
`default_nettype wire
